// ===== hdl/fire_effect_automaton_core_assert.svh =====
// Assertion macros for the fire effect automaton core.
`ifndef FIRE_EFFECT_AUTOMATON_CORE_ASSERT_SVH
`define FIRE_EFFECT_AUTOMATON_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fire core check failed");

// Next-cycle implication, checked out of reset.
`define FEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fire core check failed");

`endif

// ===== hdl/fea_pkg.sv =====
// Shared types, constants and palette for the fire effect automaton.
package fea_pkg;

    localparam int FEA_FRAME_COLS = 320;
    localparam int FEA_FRAME_ROWS = 168;

    localparam int HEAT_W = 6;
    localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd36;
    localparam logic [31:0] SEED_RESET = 32'h9E37_79B9;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2
    } fea_op_t;

    // generator control from the sequencer
    typedef struct packed {
        logic load;     // take the seed
        logic advance;  // commit one xorshift step
    } fea_rng_ctrl_t;

    localparam logic [23:0] COLOUR_TABLE [37] = '{
        24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
        24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
        24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
        24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
        24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
        24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
        24'hFFFFFF
    };

    // r in the low byte, alpha on top; black transparent for cold cells
    function automatic logic [31:0] palette_word(input logic [HEAT_W-1:0] heat);
        logic [23:0] rgb;
        rgb = 24'h0;
        if (heat == '0 || heat > HEAT_MAX) begin
            return 32'h0;
        end
        rgb = COLOUR_TABLE[heat];
        return {8'hFF, rgb[7:0], rgb[15:8], rgb[23:16]};
    endfunction

endpackage

// ===== hdl/fea_frame_ram.sv =====
// Heat frame memory: one write port, one registered read port.
module fea_frame_ram #(
    parameter int DEPTH = fea_pkg::FEA_FRAME_COLS * fea_pkg::FEA_FRAME_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [fea_pkg::HEAT_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [fea_pkg::HEAT_W-1:0] rdata
);
    import fea_pkg::*;

    logic [HEAT_W-1:0] mem [DEPTH];
    logic [HEAT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fea_spread_unit.sv =====
// Shared spread unit: xorshift32 generator, offset draw and target address.
module fea_spread_unit #(
    parameter int FRAME_COLS = fea_pkg::FEA_FRAME_COLS,
    parameter int AW         = 17
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fea_pkg::fea_rng_ctrl_t     ctrl,
    input  logic [31:0]                seed,
    input  logic [AW-1:0]              src,
    input  logic [fea_pkg::HEAT_W-1:0] heat,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [fea_pkg::HEAT_W-1:0] wr_heat
);
    import fea_pkg::*;

    localparam int TW = AW + 1;
    localparam logic [TW-1:0] W_T = TW'(FRAME_COLS);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] s1, s2;
    logic [25:0] scaled;
    logic [1:0]  r;
    logic [TW-1:0] src_p1, limit, tgt;

    always_comb begin
        s1         = state_reg ^ (state_reg << 13);
        s2         = s1 ^ (s1 >> 17);
        state_next = s2 ^ (s2 << 5);
    end

    // r = (3v + 2^23 + 1) >> 24 with v = state_next >> 8
    assign scaled = {1'b0, state_next[31:8], 1'b0} + {2'b00, state_next[31:8]}
                    + 26'd8388609;
    assign r = scaled[25:24];

    assign src_p1 = {1'b0, src} + TW'(1);
    assign limit  = W_T + TW'(r);
    assign tgt    = src_p1 - limit;

    always_comb begin
        if (heat == '0) begin
            wr_en   = 1'b1;
            wr_addr = src - AW'(FRAME_COLS);
            wr_heat = '0;
        end else begin
            wr_en   = !(src_p1 < limit);
            wr_addr = tgt[AW-1:0];
            wr_heat = heat - {{(HEAT_W-1){1'b0}}, r[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RESET;
        end else if (ctrl.load) begin
            state_reg <= seed;
        end else if (ctrl.advance) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/fire_effect_automaton_core.sv =====
// Top level of the fire effect automaton: sequencer, handshakes, result register.
//
// Fire effect cellular automaton over an in-place FRAME_COLS x FRAME_ROWS heat
// frame held in one single-port-write, registered-read RAM, with a shared
// xorshift32 spread unit. Each item on the s_ channel carries an opcode in
// s_tuser and gives exactly one result item on the m_ channel. Per opcode:
//   restart: a clearing sweep writes one cell per cycle (the bottom row to
//            HEAT_MAX, the rest to zero), then the result is loaded.
//   step:    each visited cell (rows 1 to H-1) is read, then written back.
//   read:    RAM read, palette lookup, result load.
// The result is loaded once the output register is free, and the block then
// returns to idle. The block takes one item at a time; s_tready is high only
// while idle. After reset the same clearing sweep runs before the first item
// is taken; the seed register can be written throughout. The result sits in
// an output register, so a new item is taken while it waits for m_tready.
module fire_effect_automaton_core #(
    parameter int FRAME_COLS = fea_pkg::FEA_FRAME_COLS,
    parameter int FRAME_ROWS = fea_pkg::FEA_FRAME_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // seed register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,   // rng_seed
    // command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [8:0] read_x, [16:9] read_y, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [5:0] heat_level, [37:6] pixel_rgba, rest zero
);
    import fea_pkg::*;

    localparam int CELLS  = FRAME_COLS * FRAME_ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int XW     = $clog2(FRAME_COLS);
    localparam int YW     = $clog2(FRAME_ROWS);
    localparam int BOTTOM = (FRAME_ROWS - 1) * FRAME_COLS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP_RD,
        S_STEP_WR,
        S_READ_RD,
        S_READ_OUT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]     src_reg, src_next;      // cell index: sweep and step walker
    logic [XW-1:0]     x_reg, x_next;
    logic [YW-1:0]     y_reg, y_next;
    logic [8:0]        rx_reg, rx_next;
    logic [7:0]        ry_reg, ry_next;
    logic              pend_reg, pend_next;    // an item is in flight during a sweep
    logic [HEAT_W-1:0] res_heat_reg, res_heat_next;
    logic [31:0]       res_pix_reg, res_pix_next;
    logic              m_valid_reg, m_valid_next;
    logic [HEAT_W-1:0] m_heat_reg, m_heat_next;
    logic [31:0]       m_pix_reg, m_pix_next;
    logic [31:0]       seed_reg;

    logic              accept;
    fea_op_t           op;
    fea_rng_ctrl_t     rng_ctrl;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [HEAT_W-1:0] ram_wdata, ram_rdata;
    logic              sp_en;
    logic [AW-1:0]     sp_addr;
    logic [HEAT_W-1:0] sp_heat;
    logic [31:0]       rd_lin;
    logic              rd_in_range;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign op        = fea_op_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (cfg_valid && cfg_ready) begin
            seed_reg <= cfg_data;
        end
    end

    // read address and bounds for the read command
    assign rd_lin      = 32'(ry_reg) * 32'(FRAME_COLS) + 32'(rx_reg);
    assign rd_in_range = (32'(rx_reg) < 32'(FRAME_COLS)) && (32'(ry_reg) < 32'(FRAME_ROWS));
    assign ram_raddr   = (state_reg == S_READ_RD) ? rd_lin[AW-1:0] : src_reg;

    assign rng_ctrl.load    = accept && (op == OP_RESTART);
    assign rng_ctrl.advance = (state_reg == S_STEP_WR) && (ram_rdata != '0);

    fea_spread_unit #(
        .FRAME_COLS (FRAME_COLS),
        .AW         (AW)
    ) u_spread (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rng_ctrl),
        .seed    (seed_reg),
        .src     (src_reg),
        .heat    (ram_rdata),
        .wr_en   (sp_en),
        .wr_addr (sp_addr),
        .wr_heat (sp_heat)
    );

    // write port: clearing sweep or step write-back
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = src_reg;
        ram_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (32'(src_reg) >= 32'(BOTTOM)) ? HEAT_MAX : '0;
            end
            S_STEP_WR: begin
                ram_we    = sp_en;
                ram_waddr = sp_addr;
                ram_wdata = sp_heat;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fea_frame_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next    = state_reg;
        src_next      = src_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        pend_next     = pend_reg;
        res_heat_next = res_heat_reg;
        res_pix_next  = res_pix_reg;
        m_valid_next  = m_valid_reg;
        m_heat_next   = m_heat_reg;
        m_pix_next    = m_pix_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                src_next = src_reg + AW'(1);
                if (src_reg == AW'(CELLS - 1)) begin
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    pend_next     = 1'b1;
                    res_heat_next = '0;
                    res_pix_next  = '0;
                    case (op)
                        OP_RESTART: begin
                            src_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_STEP: begin
                            x_next     = '0;
                            y_next     = YW'(1);
                            src_next   = AW'(FRAME_COLS);
                            state_next = S_STEP_RD;
                        end
                        OP_READ: begin
                            rx_next    = s_tdata[8:0];
                            ry_next    = s_tdata[16:9];
                            state_next = S_READ_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP_RD: begin
                state_next = S_STEP_WR;
            end
            S_STEP_WR: begin
                if (y_reg == YW'(FRAME_ROWS - 1)) begin
                    if (x_reg == XW'(FRAME_COLS - 1)) begin
                        state_next = S_DONE;
                    end else begin
                        // next column, back to row 1
                        x_next     = x_reg + XW'(1);
                        y_next     = YW'(1);
                        src_next   = AW'(FRAME_COLS + 32'(x_reg) + 1);
                        state_next = S_STEP_RD;
                    end
                end else begin
                    y_next     = y_reg + YW'(1);
                    src_next   = src_reg + AW'(FRAME_COLS);
                    state_next = S_STEP_RD;
                end
            end
            S_READ_RD: begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT: begin
                if (rd_in_range) begin
                    res_heat_next = ram_rdata;
                    res_pix_next  = palette_word(ram_rdata);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_heat_next  = res_heat_reg;
                    m_pix_next   = res_pix_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            src_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            src_reg     <= src_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg        <= x_next;
        y_reg        <= y_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        res_heat_reg <= res_heat_next;
        res_pix_reg  <= res_pix_next;
        m_heat_reg   <= m_heat_next;
        m_pix_reg    <= m_pix_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_pix_reg, m_heat_reg};

    `include "fire_effect_automaton_core_assert.svh"

    // frame RAM is never written while waiting for a command or a result slot
    `FEA_ASSERT_NOW(a_no_write_idle, (state_reg == S_IDLE || state_reg == S_DONE), !ram_we)
    // a restart starts the sweep at cell zero
    `FEA_ASSERT_NEXT(a_restart_sweep, (accept && op == OP_RESTART), (state_reg == S_CLEAR && src_reg == '0))
    // the step walker never visits the top row
    `FEA_ASSERT_NOW(a_step_row, (state_reg == S_STEP_RD || state_reg == S_STEP_WR), (y_reg != '0))
    // a warm cell always comes out opaque
    `FEA_ASSERT_NOW(a_warm_opaque, (m_tvalid && m_tdata[5:0] != 6'd0), (m_tdata[37:30] == 8'hFF))

endmodule
